/* rtl/edf_pkg.sv */
// Package: types and constants for the EDF heap with slack admission.
package edf_pkg;

  localparam int unsigned DefCapacity = 64;

  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_ADMIT = 2'd1;
  localparam logic [1:0] KIND_DEQ   = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic signed [39:0] SlackMin = {1'b1, 39'd0};

  typedef struct packed {
    logic [15:0]        id;
    logic [31:0]        deadline;
    logic [31:0]        exec_time;
    logic signed [39:0] slack;
  } job_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        job_id;
    logic [31:0]        deadline;
    logic [31:0]        exec_time;
    logic signed [39:0] job_slack;
    logic signed [39:0] avail_slack;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        head_job_id;
    logic [31:0]        head_deadline;
    logic [31:0]        head_exec_time;
    logic signed [39:0] head_slack;
    logic               is_empty;
    logic [6:0]         occupancy;
  } rsp_t;

  function automatic logic signed [39:0] sat_sub(logic signed [39:0] a, logic [31:0] b);
    logic signed [41:0] r;
    r = 42'(a) - $signed({10'd0, b});
    return (r < 42'(SlackMin)) ? SlackMin : r[39:0];
  endfunction

endpackage

/* rtl/edf_heap_with_slack_admission.sv */
// Top level: EDF min-heap job queue with slack admission, entries in one RAM.
// Enqueue sifts the new entry up; dequeue moves the last entry to the root and sifts
// it down; admission sums earlier-deadline work, checks later jobs' slack, charges
// them and inserts; full, empty and no-op commands only return the response.
// Throughput: one command at a time; busy is high from accept to result, the next
// accept comes in the same cycle as done_o at the earliest; the receiver cannot stall.
// Reset empties the heap; the entry RAM is not cleared.
module edf_heap_with_slack_admission
  import edf_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_S1, S_S2, S_S3, S_CHK, S_V2, S_V3, S_U2, S_U3,
    S_INS, S_UPR, S_UPC,
    S_DQR, S_DQW, S_DNR, S_DNL, S_DNC, S_HEAD, S_OUT
  } state_e;

  job_t mem_q [Capacity];
  job_t rd_q;
  logic [AW-1:0] ra, wa;
  logic we;
  job_t wd;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  state_e st_q;
  cmd_t cmd_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] i_q;
  logic signed [39:0] tot_q;
  job_t cur_q, oth_q;
  logic [1:0] status_q;
  logic done_q;
  rsp_t rsp_q;

  logic [CW-1:0] par;
  logic [AW+1:0] lch;
  logic signed [39:0] sub_v;
  assign par = (i_q - 1'b1) >> 1;
  assign lch = (AW+2)'({i_q, 1'b1});
  assign sub_v = sat_sub(rd_q.slack, cmd_q.exec_time);

  // Sift-down choice: smaller child that beats the moving entry, left on ties.
  logic [AW+1:0] rch;
  logic l_ok, r_ok, takel, taker;
  assign rch = lch + 1'b1;
  assign l_ok = lch < (AW+2)'(cnt_q);
  assign r_ok = rch < (AW+2)'(cnt_q);
  assign takel = l_ok && oth_q.deadline < cur_q.deadline;
  assign taker = r_ok && rd_q.deadline < (takel ? oth_q.deadline : cur_q.deadline);

  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = '0;
    wd = cur_q;
    unique case (st_q)
      S_S1, S_S2, S_V2, S_U2: ra = idx_q[AW-1:0];
      S_U3: begin
        ra = idx_q[AW-1:0];
        we = rd_q.deadline > cmd_q.deadline;
        wa = AW'(idx_q - 1'b1);
        wd = rd_q;
        wd.slack = sub_v;
      end
      S_UPR: ra = par[AW-1:0];
      S_UPC: begin
        we = 1'b1;
        wa = i_q[AW-1:0];
        wd = (i_q != 0 && rd_q.deadline > cur_q.deadline) ? rd_q : cur_q;
      end
      S_DQR: ra = AW'(cnt_q - 1'b1);
      S_DNR: ra = lch[AW-1:0];
      S_DNL: ra = AW'(lch + 1'b1);
      S_DNC: begin
        we = 1'b1;
        wa = i_q[AW-1:0];
        wd = taker ? rd_q : (takel ? oth_q : cur_q);
      end
      S_HEAD: ra = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (start) begin
          cmd_q <= cmd_i;
          status_q <= ST_DONE;
          idx_q <= '0;
          tot_q <= cmd_i.avail_slack;
          if (cmd_i.kind == KIND_ENQ || cmd_i.kind == KIND_ADMIT) begin
            if (cnt_q >= CW'(Capacity)) begin
              status_q <= ST_FULL; st_q <= S_HEAD;
            end else if (cmd_i.kind == KIND_ENQ) begin
              cur_q <= '{cmd_i.job_id, cmd_i.deadline, cmd_i.exec_time, cmd_i.job_slack};
              st_q <= S_INS;
            end else st_q <= (cnt_q == 0) ? S_CHK : S_S1;
          end else if (cmd_i.kind == KIND_DEQ) begin
            if (cnt_q == 0) begin
              status_q <= ST_EMPTY; st_q <= S_HEAD;
            end else st_q <= S_DQR;
          end else st_q <= S_HEAD;
        end
        S_S1: begin idx_q <= idx_q + 1'b1; st_q <= S_S2; end
        S_S2: begin
          if (rd_q.deadline <= cmd_q.deadline) tot_q <= sat_sub(tot_q, rd_q.exec_time);
          if (idx_q == cnt_q) st_q <= S_CHK;
          else idx_q <= idx_q + 1'b1;
        end
        S_CHK: begin
          idx_q <= CW'(1);
          cur_q <= '{cmd_q.job_id, cmd_q.deadline, cmd_q.exec_time, tot_q};
          if (tot_q < $signed({8'd0, cmd_q.exec_time})) begin
            status_q <= ST_REJECT; st_q <= S_HEAD;
          end else st_q <= (cnt_q == 0) ? S_INS : S_V2;
        end
        S_V2: begin
          if (rd_q.deadline > cmd_q.deadline &&
              sub_v < $signed({8'd0, rd_q.exec_time})) begin
            status_q <= ST_REJECT; st_q <= S_HEAD;
          end else if (idx_q == cnt_q) begin
            idx_q <= '0; st_q <= S_U2;
          end else idx_q <= idx_q + 1'b1;
        end
        S_U2: begin idx_q <= idx_q + 1'b1; st_q <= S_U3; end
        S_U3: begin
          if (idx_q == cnt_q) st_q <= S_INS;
          else idx_q <= idx_q + 1'b1;
        end
        S_INS: begin i_q <= cnt_q; cnt_q <= cnt_q + 1'b1; st_q <= S_UPR; end
        S_UPR: st_q <= S_UPC;
        S_UPC: begin
          if (i_q != 0 && rd_q.deadline > cur_q.deadline) begin
            i_q <= par; st_q <= S_UPR;
          end else st_q <= S_HEAD;
        end
        S_DQR: begin cnt_q <= cnt_q - 1'b1; i_q <= '0; st_q <= S_DQW; end
        S_DQW: begin cur_q <= rd_q; st_q <= (cnt_q == 0) ? S_HEAD : S_DNR; end
        S_DNR: st_q <= S_DNL;
        S_DNL: begin oth_q <= rd_q; st_q <= S_DNC; end
        S_DNC: begin
          if (taker) begin
            i_q <= CW'(rch); st_q <= S_DNR;
          end else if (takel) begin
            i_q <= CW'(lch); st_q <= S_DNR;
          end else st_q <= S_HEAD;
        end
        S_HEAD: st_q <= S_OUT;
        S_OUT: begin
          done_q <= 1'b1;
          rsp_q.status <= status_q;
          rsp_q.is_empty <= cnt_q == 0;
          rsp_q.occupancy <= 7'(cnt_q);
          rsp_q.head_job_id <= (cnt_q == 0) ? '0 : rd_q.id;
          rsp_q.head_deadline <= (cnt_q == 0) ? '0 : rd_q.deadline;
          rsp_q.head_exec_time <= (cnt_q == 0) ? '0 : rd_q.exec_time;
          rsp_q.head_slack <= (cnt_q == 0) ? '0 : rd_q.slack;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign busy = st_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> st_q == S_IDLE)
    else $error("result outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(Capacity))
    else $error("occupancy overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept not taken");

endmodule
